/* rtl/bacc_pkg.sv */
`timescale 1ns / 1ps

package bacc_pkg;

  // Request operations.
  localparam logic [1:0] OP_STEP  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // Fixed memory locations and counter limits.
  localparam logic [7:0] BASE_ADDRESS     = 8'd2;
  localparam logic [7:0] ADDRESS_CEILING  = 8'd253;
  localparam logic [7:0] JUMP_ADDRESS     = 8'd1;
  localparam logic [7:0] RESERVED_ADDRESS = 8'd0;

  // Instruction opcodes.
  localparam logic [7:0] OPC_HALT   = 8'd0;
  localparam logic [7:0] OPC_LOAD0  = 8'd1;
  localparam logic [7:0] OPC_LOAD1  = 8'd2;
  localparam logic [7:0] OPC_ADD    = 8'd3;
  localparam logic [7:0] OPC_SUB    = 8'd4;
  localparam logic [7:0] OPC_MUL    = 8'd5;
  localparam logic [7:0] OPC_DIV    = 8'd6;
  localparam logic [7:0] OPC_BEEP   = 8'd7;
  localparam logic [7:0] OPC_STORE  = 8'd8;
  localparam logic [7:0] OPC_PRINT  = 8'd9;
  localparam logic [7:0] OPC_CLR0   = 8'd10;
  localparam logic [7:0] OPC_CLR1   = 8'd11;
  localparam logic [7:0] OPC_JMP    = 8'd12;
  localparam logic [7:0] OPC_JEQ    = 8'd13;
  localparam logic [7:0] OPC_JNE    = 8'd14;

  // Shared arithmetic unit operations.
  localparam logic [1:0] ALU_ADD     = 2'd0;
  localparam logic [1:0] ALU_SUB     = 2'd1;
  localparam logic [1:0] ALU_MUL     = 2'd2;
  localparam logic [1:0] ALU_DIVSTEP = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] address;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic       printed;
    logic [7:0] print_value;
    logic       beeped;
    logic       halted;
    logic [7:0] counter_now;
    logic [7:0] accumulator;
  } rsp_t;

  typedef struct packed {
    logic [1:0] op;
    logic [8:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       flag;
  } alu_rsp_t;

endpackage

/* rtl/bacc_alu.sv */
`timescale 1ns / 1ps

module bacc_alu (
  input  bacc_pkg::alu_req_t cmd,
  output bacc_pkg::alu_rsp_t res
);

  always_comb begin
    logic [8:0]  sum;
    logic [15:0] prod;
    logic        ge;
    logic [8:0]  diff;
    sum  = {1'b0, cmd.a[7:0]} + {1'b0, cmd.b};
    prod = {8'd0, cmd.a[7:0]} * {8'd0, cmd.b};
    ge   = cmd.a >= {1'b0, cmd.b};
    diff = cmd.a - {1'b0, cmd.b};
    res.flag = 1'b0;
    case (cmd.op)
      bacc_pkg::ALU_ADD: begin
        // A carry out means the wrapped sum fell below the old value.
        res.value = sum[8] ? 8'd0 : sum[7:0];
      end
      bacc_pkg::ALU_SUB: begin
        res.value = (cmd.a[7:0] >= cmd.b) ? diff[7:0] : 8'd0;
      end
      bacc_pkg::ALU_MUL: begin
        res.value = ((cmd.a[7:0] > prod[7:0]) && (cmd.b != 8'd0)) ? 8'd0 : prod[7:0];
      end
      bacc_pkg::ALU_DIVSTEP: begin
        // One restoring division step on the shifted partial remainder.
        res.value = ge ? diff[7:0] : cmd.a[7:0];
        res.flag  = ge;
      end
      default: begin
        res.value = 8'd0;
      end
    endcase
  end

endmodule

/* rtl/bacc_mem.sv */
`timescale 1ns / 1ps

module bacc_mem (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);

  logic [7:0] mem [256];
  logic [255:0] written;
  logic [7:0] mem_q;
  logic       written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // A location that has never been written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      written_q <= written[rd_addr];
    end
  end

  assign rd_data = written_q ? mem_q : 8'd0;

endmodule

/* rtl/byte_accumulator_cpu_step.sv */
`timescale 1ns / 1ps

// Channel   Direction  Payload               Handshake
// request   in         bacc_pkg::req_t       req_valid / req_stall
// result    out        bacc_pkg::rsp_t       rsp_valid / rsp_stall
//
// A memory write, control reset or idle request goes from idle to write-back, and
// so does a step while halted. A step runs fetch, execute and write-back, skipping
// execute when its fetch passes the ceiling; an operand read adds an operand state,
// a printed byte also a load state, a division eight restoring steps on one ALU.
// Reset clears the state, counter, r0, r1, flags and the written marks of the memory.
// Requests are stalled while a request is in progress; a finished result sits in
// the output register, and only the final write-back waits on result stalls.
module byte_accumulator_cpu_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  bacc_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bacc_pkg::rsp_t  rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_OPND   = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [7:0] pc;
  logic [7:0] r0;
  logic [7:0] r1;
  logic       halt;
  logic [7:0] opc;
  logic       printed;
  logic [7:0] print_value;
  logic       beeped;
  logic [7:0] div_rem;
  logic [7:0] div_quo;
  logic [2:0] div_cnt;

  logic       accept;
  logic       wr_en;
  logic [7:0] wr_addr;
  logic [7:0] wr_data;
  logic [7:0] rd_addr;
  logic [7:0] rd_data;
  logic [7:0] pc_inc;
  logic       take_jump;
  logic       rsp_load;

  bacc_pkg::alu_req_t alu_cmd;
  bacc_pkg::alu_rsp_t alu_res;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign pc_inc    = pc + 8'd1;
  assign take_jump = (opc == bacc_pkg::OPC_JEQ) ? (r0 == r1) : (r0 != r1);
  assign rsp_load  = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  bacc_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bacc_alu u_alu (
    .cmd (alu_cmd),
    .res (alu_res)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req.address;
    wr_data = req.data;
    rd_addr = pc;
    alu_cmd.op = bacc_pkg::ALU_ADD;
    alu_cmd.a  = {1'b0, r0};
    alu_cmd.b  = r1;
    case (state)
      S_IDLE: begin
        wr_en = accept && (req.op == bacc_pkg::OP_WRITE);
      end
      S_FETCH: begin
        wr_en   = 1'b1;
        wr_addr = bacc_pkg::RESERVED_ADDRESS;
        wr_data = rd_data;
      end
      S_EXEC: begin
        case (opc)
          bacc_pkg::OPC_SUB: alu_cmd.op = bacc_pkg::ALU_SUB;
          bacc_pkg::OPC_MUL: alu_cmd.op = bacc_pkg::ALU_MUL;
          default:           alu_cmd.op = bacc_pkg::ALU_ADD;
        endcase
      end
      S_OPND: begin
        rd_addr = rd_data;
        if (opc == bacc_pkg::OPC_STORE) begin
          wr_en   = 1'b1;
          wr_addr = rd_data;
          wr_data = r0;
        end else if (opc == bacc_pkg::OPC_JMP || opc == bacc_pkg::OPC_JEQ ||
                     opc == bacc_pkg::OPC_JNE) begin
          wr_en   = 1'b1;
          wr_addr = bacc_pkg::JUMP_ADDRESS;
          wr_data = rd_data;
        end
      end
      S_DIV: begin
        alu_cmd.op = bacc_pkg::ALU_DIVSTEP;
        alu_cmd.a  = {div_rem, div_quo[7]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pc      <= bacc_pkg::BASE_ADDRESS;
      r0      <= 8'd0;
      r1      <= 8'd0;
      halt    <= 1'b0;
      printed <= 1'b0;
      beeped  <= 1'b0;
      div_cnt <= 3'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            printed     <= 1'b0;
            print_value <= 8'd0;
            beeped      <= 1'b0;
            state       <= S_FINISH;
            if (req.op == bacc_pkg::OP_RESET) begin
              halt <= 1'b0;
              pc   <= bacc_pkg::BASE_ADDRESS;
            end else if (req.op == bacc_pkg::OP_STEP && !halt) begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          opc <= rd_data;
          pc  <= pc_inc;
          if (pc_inc > bacc_pkg::ADDRESS_CEILING) begin
            halt  <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FINISH;
          case (opc)
            bacc_pkg::OPC_HALT: halt <= 1'b1;
            bacc_pkg::OPC_LOAD0, bacc_pkg::OPC_LOAD1, bacc_pkg::OPC_STORE,
            bacc_pkg::OPC_PRINT, bacc_pkg::OPC_JMP: begin
              pc    <= pc_inc;
              state <= S_OPND;
            end
            bacc_pkg::OPC_ADD, bacc_pkg::OPC_SUB, bacc_pkg::OPC_MUL: begin
              r0 <= alu_res.value;
            end
            bacc_pkg::OPC_DIV: begin
              if (r1 == 8'd0) begin
                r0 <= 8'd0;
              end else begin
                div_rem <= 8'd0;
                div_quo <= r0;
                div_cnt <= 3'd0;
                state   <= S_DIV;
              end
            end
            bacc_pkg::OPC_BEEP: beeped <= 1'b1;
            bacc_pkg::OPC_CLR0: r0 <= 8'd0;
            bacc_pkg::OPC_CLR1: r1 <= 8'd0;
            bacc_pkg::OPC_JEQ, bacc_pkg::OPC_JNE: begin
              pc <= pc_inc;
              if (take_jump) begin
                state <= S_OPND;
              end
            end
            default: halt <= 1'b1;
          endcase
        end
        S_OPND: begin
          state <= S_FINISH;
          case (opc)
            bacc_pkg::OPC_LOAD0: r0 <= rd_data;
            bacc_pkg::OPC_LOAD1, bacc_pkg::OPC_STORE: r1 <= rd_data;
            bacc_pkg::OPC_PRINT: begin
              r1    <= rd_data;
              state <= S_LOAD;
            end
            default: pc <= rd_data;
          endcase
        end
        S_LOAD: begin
          r0          <= rd_data;
          printed     <= 1'b1;
          print_value <= rd_data;
          state       <= S_FINISH;
        end
        S_DIV: begin
          div_rem <= alu_res.value;
          div_quo <= {div_quo[6:0], alu_res.flag};
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            r0    <= {div_quo[6:0], alu_res.flag};
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.printed     <= printed;
      rsp.print_value <= print_value;
      rsp.beeped      <= beeped;
      rsp.halted      <= halt;
      rsp.counter_now <= pc;
      rsp.accumulator <= r0;
    end
  end

  // A fresh result only ever comes from the write-back state.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside write-back");

  // The halt flag is only set by a fetch past the ceiling or by execution.
  a_halt_source: assert property (@(posedge clk) disable iff (rst)
    $rose(halt) |-> ($past(state) == S_FETCH) || ($past(state) == S_EXEC))
    else $error("halt set from an unexpected state");

  // Division runs exactly eight steps.
  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (div_cnt == 3'd7) |=> state == S_FINISH)
    else $error("division did not finish after eight steps");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request accepted without starting work");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] OP_UNUSED         = 2'd3;
  localparam logic [7:0] OPC_FIRST_UNKNOWN = 8'd15;
  localparam logic [7:0] DATA_LO           = 8'd200;
  localparam logic [7:0] DATA_HI           = 8'd252;
  localparam int unsigned ITEM_TARGET  = 1350;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_START   = 1500;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned CALM_FIRST   = 5000;
  localparam int unsigned CALM_LAST    = 8000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bacc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bacc_pkg::rsp_t rsp;

  bacc_pkg::req_t pending_reqs[$];
  bacc_pkg::rsp_t expected_results[$];
  bacc_pkg::rsp_t want_rsp;
  logic req_taken = 1'b0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  int unsigned n_errors = 0;

  // Shadow copy of the machine.
  logic [7:0] mem_img [256];
  logic [7:0] pc_img;
  logic [7:0] r0_img;
  logic [7:0] r1_img;
  logic       halted_img;

  byte_accumulator_cpu_step u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] take_operand();
    logic [7:0] v;
    v = mem_img[pc_img];
    pc_img = pc_img + 8'd1;
    return v;
  endfunction

  // The target passes through the jump location before it reaches the counter.
  function automatic void take_jump();
    logic [7:0] tgt;
    tgt = take_operand();
    mem_img[bacc_pkg::JUMP_ADDRESS] = tgt;
    pc_img = mem_img[bacc_pkg::JUMP_ADDRESS];
  endfunction

  function automatic bacc_pkg::rsp_t apply_request(bacc_pkg::req_t rq);
    bacc_pkg::rsp_t res;
    logic [7:0] opc;
    logic [7:0] prior;
    res = '0;
    case (rq.op)
      bacc_pkg::OP_STEP: begin
        if (!halted_img) begin
          opc = mem_img[pc_img];
          pc_img = pc_img + 8'd1;
          if (pc_img > bacc_pkg::ADDRESS_CEILING) halted_img = 1'b1;
          mem_img[bacc_pkg::RESERVED_ADDRESS] = opc;
          if (!halted_img) begin
            case (opc)
              bacc_pkg::OPC_HALT:  halted_img = 1'b1;
              bacc_pkg::OPC_LOAD0: r0_img = take_operand();
              bacc_pkg::OPC_LOAD1: r1_img = take_operand();
              bacc_pkg::OPC_ADD: begin
                prior = r0_img;
                r0_img = r0_img + r1_img;
                if (prior > r0_img) r0_img = 8'd0;
              end
              bacc_pkg::OPC_SUB: r0_img = (r0_img >= r1_img) ? r0_img - r1_img : 8'd0;
              bacc_pkg::OPC_MUL: begin
                prior = r0_img;
                r0_img = r0_img * r1_img;
                if (prior > r0_img && r1_img != 8'd0) r0_img = 8'd0;
              end
              bacc_pkg::OPC_DIV:  r0_img = (r1_img != 8'd0) ? r0_img / r1_img : 8'd0;
              bacc_pkg::OPC_BEEP: res.beeped = 1'b1;
              bacc_pkg::OPC_STORE: begin
                r1_img = take_operand();
                mem_img[r1_img] = r0_img;
              end
              bacc_pkg::OPC_PRINT: begin
                r1_img = take_operand();
                r0_img = mem_img[r1_img];
                res.printed = 1'b1;
                res.print_value = r0_img;
              end
              bacc_pkg::OPC_CLR0: r0_img = 8'd0;
              bacc_pkg::OPC_CLR1: r1_img = 8'd0;
              bacc_pkg::OPC_JMP:  take_jump();
              bacc_pkg::OPC_JEQ: begin
                if (r0_img == r1_img) take_jump();
                else pc_img = pc_img + 8'd1;
              end
              bacc_pkg::OPC_JNE: begin
                if (r0_img != r1_img) take_jump();
                else pc_img = pc_img + 8'd1;
              end
              default: halted_img = 1'b1;
            endcase
          end
        end
      end
      bacc_pkg::OP_WRITE: mem_img[rq.address] = rq.data;
      bacc_pkg::OP_RESET: begin
        halted_img = 1'b0;
        pc_img = bacc_pkg::BASE_ADDRESS;
      end
      default: ;
    endcase
    res.halted = halted_img;
    res.counter_now = pc_img;
    res.accumulator = r0_img;
    return res;
  endfunction

  function automatic bit idle_now();
    if (cyc >= CALM_FIRST && cyc < CALM_LAST) return 1'b0;
    return $urandom_range(0, 99) < 13;
  endfunction

  task automatic push_req(input logic [1:0] op, input logic [7:0] address,
                          input logic [7:0] data);
    bacc_pkg::req_t rq;
    rq.op = op;
    rq.address = address;
    rq.data = data;
    pending_reqs.push_back(rq);
  endtask

  // Loads a short random program at the base address, some data bytes, then
  // restarts the machine and steps it.
  task automatic build_program();
    int unsigned len;
    int unsigned r;
    logic [7:0] a;
    logic [7:0] opc;
    logic [7:0] arg;
    bit has_arg;
    a = bacc_pkg::BASE_ADDRESS;
    len = $urandom_range(3, 16);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 3) opc = bacc_pkg::OPC_HALT;
      else if (r < 6) opc = 8'($urandom_range(OPC_FIRST_UNKNOWN, 255));
      else opc = 8'($urandom_range(bacc_pkg::OPC_LOAD0, bacc_pkg::OPC_JNE));
      push_req(bacc_pkg::OP_WRITE, a, opc);
      a = a + 8'd1;
      has_arg = 1'b1;
      r = $urandom_range(0, 99);
      case (opc)
        bacc_pkg::OPC_LOAD0, bacc_pkg::OPC_LOAD1: begin
          if (r < 20) arg = 8'd0;
          else if (r < 30) arg = 8'd255;
          else arg = 8'($urandom_range(0, 255));
        end
        bacc_pkg::OPC_STORE, bacc_pkg::OPC_PRINT: begin
          if (r < 70) arg = 8'($urandom_range(DATA_LO, DATA_HI));
          else arg = 8'($urandom_range(0, 255));
        end
        bacc_pkg::OPC_JMP, bacc_pkg::OPC_JEQ, bacc_pkg::OPC_JNE: begin
          if (r < 80)
            arg = 8'($urandom_range(bacc_pkg::BASE_ADDRESS,
                                    bacc_pkg::BASE_ADDRESS + 2 * len));
          else if (r < 90) arg = 8'($urandom_range(0, 255));
          else arg = 8'($urandom_range(bacc_pkg::ADDRESS_CEILING, 255));
        end
        default: has_arg = 1'b0;
      endcase
      if (has_arg) begin
        push_req(bacc_pkg::OP_WRITE, a, arg);
        a = a + 8'd1;
      end
    end
    repeat ($urandom_range(0, 3))
      push_req(bacc_pkg::OP_WRITE, 8'($urandom_range(DATA_LO, DATA_HI)),
               8'($urandom_range(0, 255)));
    push_req(bacc_pkg::OP_RESET, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(len, 2 * len + 6))
      push_req(bacc_pkg::OP_STEP, 8'($urandom), 8'($urandom));
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_reqs.size() != 0 && !idle_now()) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off to back the block up.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (cyc == HOLD_START) begin
      hold_left <= HOLD_LEN;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !rst && idle_now();
    end
  end

  // Monitor: checks results and predicts each accepted request.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          want_rsp = expected_results.pop_front();
          check_field("printed", 8'(want_rsp.printed), 8'(rsp.printed));
          check_field("print_value", want_rsp.print_value, rsp.print_value);
          check_field("beeped", 8'(want_rsp.beeped), 8'(rsp.beeped));
          check_field("halted", 8'(want_rsp.halted), 8'(rsp.halted));
          check_field("counter_now", want_rsp.counter_now, rsp.counter_now);
          check_field("accumulator", want_rsp.accumulator, rsp.accumulator);
        end
      end
      if (req_valid && !req_stall) expected_results.push_back(apply_request(req));
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) mem_img[i] = 8'd0;
    pc_img = bacc_pkg::BASE_ADDRESS;
    r0_img = 8'd0;
    r1_img = 8'd0;
    halted_img = 1'b0;

    // Cleared memory holds halt opcodes; a second step finds the machine halted.
    push_req(bacc_pkg::OP_STEP, 8'd0, 8'd0);
    push_req(bacc_pkg::OP_STEP, 8'd255, 8'd255);
    push_req(bacc_pkg::OP_WRITE, 8'd255, 8'd255);
    push_req(OP_UNUSED, 8'd255, 8'd255);
    push_req(bacc_pkg::OP_RESET, 8'd0, 8'd0);
    // Add overflow, subtract underflow and division by zero, then a jump to the
    // top byte, whose fetch wraps the counter and meets an unknown opcode.
    push_req(bacc_pkg::OP_WRITE, 8'd2, bacc_pkg::OPC_LOAD0);
    push_req(bacc_pkg::OP_WRITE, 8'd3, 8'd200);
    push_req(bacc_pkg::OP_WRITE, 8'd4, bacc_pkg::OPC_LOAD1);
    push_req(bacc_pkg::OP_WRITE, 8'd5, 8'd100);
    push_req(bacc_pkg::OP_WRITE, 8'd6, bacc_pkg::OPC_ADD);
    push_req(bacc_pkg::OP_WRITE, 8'd7, bacc_pkg::OPC_SUB);
    push_req(bacc_pkg::OP_WRITE, 8'd8, bacc_pkg::OPC_CLR1);
    push_req(bacc_pkg::OP_WRITE, 8'd9, bacc_pkg::OPC_DIV);
    push_req(bacc_pkg::OP_WRITE, 8'd10, bacc_pkg::OPC_JMP);
    push_req(bacc_pkg::OP_WRITE, 8'd11, 8'd255);
    repeat (8) push_req(bacc_pkg::OP_STEP, 8'd0, 8'd0);

    while (pending_reqs.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          push_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end else begin
        build_program();
      end
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
